### rtl/core/accroll_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accroll_pkg
// Types and constants shared by the averaged accelerometer roll-angle block.
// ----------------------------------------------------------------------------
package accroll_pkg;

   // One accelerometer sample request.
   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic               read_failed;
   } accroll_req_type;

   // One roll-angle result.
   typedef struct packed {
      logic signed [16:0] roll_angle;
      logic               failed;
   } accroll_rsp_type;

   // CORDIC angle accumulator: degrees with 16 fraction bits.
   localparam int ANGLE_W = 25;
   localparam int CORDIC_STEPS = 22;
   localparam int STEP_IDX_W = 5;
   localparam logic signed [ANGLE_W-1:0] ANGLE_90_Q16 = 25'sd5898240;

   // Result saturation bounds, degrees with 8 fraction bits.
   localparam logic signed [17:0] ROLL_CEIL = 18'sd46080;
   localparam logic signed [17:0] ROLL_FLOOR = -18'sd46080;

   // atan(2^-i) in degrees with 16 fraction bits, rounded to nearest.
   function automatic logic signed [ANGLE_W-1:0] atan_deg_q16(
      input logic [STEP_IDX_W-1:0] idx);
      logic signed [ANGLE_W-1:0] val;
      unique case (idx)
         5'd0:    val = 25'sd2949120;
         5'd1:    val = 25'sd1740967;
         5'd2:    val = 25'sd919879;
         5'd3:    val = 25'sd466945;
         5'd4:    val = 25'sd234379;
         5'd5:    val = 25'sd117304;
         5'd6:    val = 25'sd58666;
         5'd7:    val = 25'sd29335;
         5'd8:    val = 25'sd14668;
         5'd9:    val = 25'sd7334;
         5'd10:   val = 25'sd3667;
         5'd11:   val = 25'sd1833;
         5'd12:   val = 25'sd917;
         5'd13:   val = 25'sd458;
         5'd14:   val = 25'sd229;
         5'd15:   val = 25'sd115;
         5'd16:   val = 25'sd57;
         5'd17:   val = 25'sd29;
         5'd18:   val = 25'sd14;
         5'd19:   val = 25'sd7;
         5'd20:   val = 25'sd4;
         5'd21:   val = 25'sd2;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

### rtl/core/accel_roll_angle_averaged.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_roll_angle_averaged
// Sums accelerometer samples over a group and reports the roll angle
// atan2(y, sqrt(x^2 + z^2)) in degrees (8 fraction bits) minus an offset.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  accroll_req_type (x, y, z, fail)
// rsp      out        rsp_valid / rsp_ready  accroll_rsp_type (angle, fail)
// csr      in         csr_wen                csr_wdata (roll offset, Q8 deg)
//
// A sample that does not close a group is absorbed while the block stays
// idle. The closing sample starts the sequencer: two squarings on one
// multiplier, one add, a restoring square root of SUM_W + 8 steps, 22 CORDIC
// steps on one shift/add unit, then rounding and offset. A zero y sum, or
// zero x and z sums, skip the root and CORDIC. A failed read goes straight
// to the output hold. Reset is synchronous and clears the group and the
// offset. The finished result sits in an output register, so a stalled rsp
// side holds back new requests only once a second result is ready.
//
module accel_roll_angle_averaged #(
   parameter int SAMPLES_AVERAGED = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  accroll_pkg::accroll_req_type req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output accroll_pkg::accroll_rsp_type rsp_data,
   input  logic                         csr_wen,
   input  logic signed [15:0]           csr_wdata
);

   // Widths that follow from the group size.
   localparam int CNT_W = (SAMPLES_AVERAGED > 1) ? $clog2(SAMPLES_AVERAGED) : 1;
   localparam int SUM_W = 16 + $clog2(SAMPLES_AVERAGED);
   localparam int SQ_W = 2 * SUM_W;
   localparam int RAD_W = SQ_W + 16;
   localparam int ROOT_W = SUM_W + 8;
   localparam int REM_W = ROOT_W + 1;
   localparam int CW = SUM_W + 11;
   localparam int ITER_W = $clog2(ROOT_W);
   localparam int AW = accroll_pkg::ANGLE_W;

   // The sequencer walks these states in order; failures jump to HOLD and zero sums skip to ANGLE.
   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_MULX   = 9'b000000010,
      ST_MULZ   = 9'b000000100,
      ST_SUMSQ  = 9'b000001000,
      ST_ROOT   = 9'b000010000,
      ST_ROT    = 9'b000100000,
      ST_ANGLE  = 9'b001000000,
      ST_OFFSET = 9'b010000000,
      ST_HOLD   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic signed [SUM_W-1:0] sum_x_ff, sum_x_in;
   logic signed [SUM_W-1:0] sum_y_ff, sum_y_in;
   logic signed [SUM_W-1:0] sum_z_ff, sum_z_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [15:0]      offset_ff, offset_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   accroll_pkg::accroll_rsp_type rsp_data_ff, rsp_data_in;

   logic [SQ_W-1:0]         prod_ff, prod_in;
   logic [SQ_W-1:0]         acc_ff, acc_in;
   logic [RAD_W-1:0]        rad_ff, rad_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [ROOT_W-1:0]       root_ff, root_in;
   logic [ITER_W-1:0]       iter_ff, iter_in;
   logic signed [CW-1:0]    x_ff, x_in;
   logic signed [CW-1:0]    y_ff, y_in;
   logic signed [AW-1:0]    z_ff, z_in;
   logic                    sign_ff, sign_in;
   logic                    yzero_ff, yzero_in;
   logic signed [16:0]      res_angle_ff, res_angle_in;
   logic                    res_fail_ff, res_fail_in;

   // Shared multiplier: squares one axis sum per cycle.
   logic signed [SUM_W-1:0] mul_op;
   logic signed [SQ_W-1:0]  mul_prod;

   // Square-root step.
   logic [SQ_W-1:0]         sumsq;
   logic [REM_W+1:0]        rem_sh;
   logic [REM_W+1:0]        trial;
   logic [REM_W+1:0]        rem_diff;
   logic                    root_bit;
   logic [ROOT_W-1:0]       root_next;

   // CORDIC step.
   logic signed [CW-1:0]    x_shift;
   logic signed [CW-1:0]    y_shift;
   logic signed [AW-1:0]    atan_step;

   // Final angle and offset.
   logic [SUM_W-1:0]        ay_mag;
   logic [22:0]             z_clamp;
   logic [22:0]             z_round;
   logic [16:0]             ang_mag;
   logic signed [17:0]      roll_diff;

   logic                    req_fire;
   logic                    rsp_load;
   logic                    group_last;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign group_last = (count_ff == CNT_W'(SAMPLES_AVERAGED - 1));
   assign rsp_load   = (state_ff == ST_HOLD) && (!rsp_valid_ff || rsp_ready);

   assign mul_op   = (state_ff == ST_MULX) ? sum_x_ff : sum_z_ff;
   assign mul_prod = mul_op * mul_op;

   assign sumsq     = acc_ff + prod_ff;
   // Bring down the next two radicand bits and try the next root bit.
   assign rem_sh    = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial     = (REM_W + 2)'({root_ff, 2'b01});
   assign rem_diff  = rem_sh - trial;
   assign root_bit  = (rem_sh >= trial);
   assign root_next = {root_ff[ROOT_W-2:0], root_bit};

   assign x_shift   = x_ff >>> iter_ff[accroll_pkg::STEP_IDX_W-1:0];
   assign y_shift   = y_ff >>> iter_ff[accroll_pkg::STEP_IDX_W-1:0];
   assign atan_step = accroll_pkg::atan_deg_q16(iter_ff[accroll_pkg::STEP_IDX_W-1:0]);

   assign ay_mag = sum_y_ff[SUM_W-1] ? (~sum_y_ff + SUM_W'(1)) : sum_y_ff;

   always_comb begin
      if (z_ff[AW-1]) begin
         z_clamp = '0;
      end else if (z_ff > accroll_pkg::ANGLE_90_Q16) begin
         z_clamp = accroll_pkg::ANGLE_90_Q16[22:0];
      end else begin
         z_clamp = z_ff[22:0];
      end
   end

   assign z_round   = z_clamp + 23'd128;
   assign ang_mag   = {2'b00, z_round[22:8]};
   assign roll_diff = 18'(res_angle_ff) - 18'(offset_ff);

   always_comb begin
      state_in     = state_ff;
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      sum_z_in     = sum_z_ff;
      count_in     = count_ff;
      offset_in    = csr_wen ? csr_wdata : offset_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      iter_in      = iter_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      sign_in      = sign_ff;
      yzero_in     = yzero_ff;
      res_angle_in = res_angle_ff;
      res_fail_in  = res_fail_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.read_failed) begin
                  // Abort the group and report a zero angle, no offset.
                  sum_x_in     = '0;
                  sum_y_in     = '0;
                  sum_z_in     = '0;
                  count_in     = '0;
                  res_angle_in = '0;
                  res_fail_in  = 1'b1;
                  state_in     = ST_HOLD;
               end else begin
                  sum_x_in = sum_x_ff + SUM_W'(req_data.accel_x);
                  sum_y_in = sum_y_ff + SUM_W'(req_data.accel_y);
                  sum_z_in = sum_z_ff + SUM_W'(req_data.accel_z);
                  if (group_last) begin
                     count_in = '0;
                     state_in = ST_MULX;
                  end else begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end
            end
         end
         ST_MULX: begin
            prod_in  = mul_prod;
            y_in     = CW'({ay_mag, 8'b0});
            sign_in  = sum_y_ff[SUM_W-1];
            yzero_in = (sum_y_ff == '0);
            state_in = ST_MULZ;
         end
         ST_MULZ: begin
            acc_in   = prod_ff;
            prod_in  = mul_prod;
            state_in = ST_SUMSQ;
         end
         ST_SUMSQ: begin
            // The sums are consumed; the next group starts from zero.
            sum_x_in = '0;
            sum_y_in = '0;
            sum_z_in = '0;
            rad_in   = {sumsq, 16'b0};
            rem_in   = '0;
            root_in  = '0;
            iter_in  = '0;
            if (yzero_ff) begin
               z_in     = '0;
               state_in = ST_ANGLE;
            end else if (sumsq == '0) begin
               // Horizontal axes both zero: straight up or down.
               z_in     = accroll_pkg::ANGLE_90_Q16;
               state_in = ST_ANGLE;
            end else begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            rem_in  = root_bit ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
            root_in = root_next;
            rad_in  = rad_ff << 2;
            iter_in = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_W'(ROOT_W - 1)) begin
               x_in     = CW'(root_next);
               z_in     = '0;
               iter_in  = '0;
               state_in = ST_ROT;
            end
         end
         ST_ROT: begin
            // Vectoring mode: drive y toward zero and collect the angle.
            if (!y_ff[CW-1]) begin
               x_in = x_ff + y_shift;
               y_in = y_ff - x_shift;
               z_in = z_ff + atan_step;
            end else begin
               x_in = x_ff - y_shift;
               y_in = y_ff + x_shift;
               z_in = z_ff - atan_step;
            end
            iter_in = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_W'(accroll_pkg::CORDIC_STEPS - 1)) begin
               state_in = ST_ANGLE;
            end
         end
         ST_ANGLE: begin
            res_angle_in = sign_ff ? (~ang_mag + 17'd1) : ang_mag;
            state_in     = ST_OFFSET;
         end
         ST_OFFSET: begin
            if (roll_diff > accroll_pkg::ROLL_CEIL) begin
               res_angle_in = accroll_pkg::ROLL_CEIL[16:0];
            end else if (roll_diff < accroll_pkg::ROLL_FLOOR) begin
               res_angle_in = accroll_pkg::ROLL_FLOOR[16:0];
            end else begin
               res_angle_in = roll_diff[16:0];
            end
            res_fail_in = 1'b0;
            state_in    = ST_HOLD;
         end
         ST_HOLD: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: loads the finished result once the slot is free.
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (rsp_load) begin
         rsp_data_in.roll_angle = res_angle_ff;
         rsp_data_in.failed     = res_fail_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         sum_z_ff     <= '0;
         count_ff     <= '0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         sum_z_ff     <= sum_z_in;
         count_ff     <= count_in;
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      rad_ff       <= rad_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      iter_ff      <= iter_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      z_ff         <= z_in;
      sign_ff      <= sign_in;
      yzero_ff     <= yzero_in;
      res_angle_ff <= res_angle_in;
      res_fail_ff  <= res_fail_in;
   end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the averaged accelerometer roll-angle block.
// Sample requests are driven through a valid/ready channel while a bit-exact
// model of the group sums, square root, CORDIC, offset and saturation
// predicts every result, and the result channel is compared field by field.
// ----------------------------------------------------------------------------
module tb;

   localparam int CLOCK_HALF    = 6;
   localparam int LIMIT_CYCLES  = 1_000_000;
   // Long enough for the closing sample of a group to pass the sequencer, with a margin.
   localparam int SETTLE_CYCLES = 100;
   localparam int HOLD_CYCLES   = 400;
   localparam int GROUP_SIZE    = 4;
   localparam int ROTATIONS     = 22;
   localparam longint ROLL_BOUND = 46080;
   localparam longint RIGHT_ANGLE_Q16 = 5898240;

   // atan(2^-i) in degrees with 16 fraction bits, rounded to nearest.
   localparam longint ATAN_Q16 [ROTATIONS] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2
   };

   // How the samples of one group are drawn.
   typedef enum int {
      STYLE_SPREAD,
      STYLE_TILTED,
      STYLE_CORNER
   } group_style_type;

   // -------------------------------------------------------------------------
   // Roll-angle ledger: keeps its own copy of the group sums and the offset,
   // predicts the result of every accepted request and checks each result
   // against the oldest prediction.
   // -------------------------------------------------------------------------
   class roll_angle_ledger;
      longint sum_x = 0;
      longint sum_y = 0;
      longint sum_z = 0;
      int group_count = 0;
      longint roll_offset = 0;
      accroll_pkg::accroll_rsp_type expected_angles[$];
      int mismatches = 0;
      int results_checked = 0;
      int failed_results = 0;
      int saturated_results = 0;

      function void clear_group();
         sum_x = 0;
         sum_y = 0;
         sum_z = 0;
         group_count = 0;
      endfunction

      // Roll in degrees with 8 fraction bits from the current sums.
      function longint predict_roll();
         longint unsigned mag_x, mag_z, rem, root, probe;
         longint x, y, z, xs, ys, angle;
         int i;
         if (sum_y == 0) return 0;
         mag_x = (sum_x < 0) ? -sum_x : sum_x;
         mag_z = (sum_z < 0) ? -sum_z : sum_z;
         rem = (mag_x * mag_x + mag_z * mag_z) << 16;
         // Integer square root, one result bit per pass.
         root = 0;
         probe = 64'h4000_0000_0000_0000;
         while (probe > rem) probe >>= 2;
         while (probe != 0) begin
            if (rem >= root + probe) begin
               rem -= root + probe;
               root = (root >> 1) + probe;
            end else begin
               root >>= 1;
            end
            probe >>= 2;
         end
         x = longint'(root);
         y = ((sum_y < 0) ? -sum_y : sum_y) * 256;
         z = 0;
         if (x == 0) begin
            z = RIGHT_ANGLE_Q16;
         end else begin
            // Vectoring rotations; arithmetic shifts round toward minus infinity.
            for (i = 0; i < ROTATIONS; i++) begin
               xs = x >>> i;
               ys = y >>> i;
               if (y >= 0) begin
                  x += ys;
                  y -= xs;
                  z += ATAN_Q16[i];
               end else begin
                  x -= ys;
                  y += xs;
                  z -= ATAN_Q16[i];
               end
            end
            if (z < 0) z = 0;
            if (z > RIGHT_ANGLE_Q16) z = RIGHT_ANGLE_Q16;
         end
         angle = (z + 128) >>> 8;
         return (sum_y < 0) ? -angle : angle;
      endfunction

      function void note_sample(accroll_pkg::accroll_req_type s);
         accroll_pkg::accroll_rsp_type e;
         longint r;
         if (s.read_failed) begin
            // A failed read aborts the group: angle 0, offset not applied.
            clear_group();
            e.roll_angle = '0;
            e.failed = 1'b1;
            expected_angles.push_back(e);
            failed_results++;
            return;
         end
         sum_x += longint'(s.accel_x);
         sum_y += longint'(s.accel_y);
         sum_z += longint'(s.accel_z);
         group_count++;
         if (group_count < GROUP_SIZE) return;
         r = predict_roll() - roll_offset;
         if (r > ROLL_BOUND) begin
            r = ROLL_BOUND;
            saturated_results++;
         end
         if (r < -ROLL_BOUND) begin
            r = -ROLL_BOUND;
            saturated_results++;
         end
         clear_group();
         e.roll_angle = 17'(r);
         e.failed = 1'b0;
         expected_angles.push_back(e);
      endfunction

      function void check_result(accroll_pkg::accroll_rsp_type got);
         accroll_pkg::accroll_rsp_type e;
         results_checked++;
         if (expected_angles.size() == 0) begin
            $error("unexpected result: roll_angle %0d failed %0b",
                   got.roll_angle, got.failed);
            mismatches++;
            return;
         end
         e = expected_angles.pop_front();
         if (got.roll_angle !== e.roll_angle) begin
            $error("roll_angle: expected %0d, actual %0d", e.roll_angle, got.roll_angle);
            mismatches++;
         end
         if (got.failed !== e.failed) begin
            $error("failed: expected %0b, actual %0b", e.failed, got.failed);
            mismatches++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and the block's ports. Every input starts at a known value.
   // -------------------------------------------------------------------------
   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   accroll_pkg::accroll_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   accroll_pkg::accroll_rsp_type rsp_data;
   logic csr_wen = 1'b0;
   logic signed [15:0] csr_wdata = '0;

   roll_angle_ledger ledger;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   // Remaining cycles of a long receiver hold-off; counted down below.
   int hold_left = 0;
   int samples_sent = 0;
   int offsets_written = 0;
   int cycles = 0;

   accel_roll_angle_averaged u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers.
   // -------------------------------------------------------------------------
   function automatic logic signed [15:0] corner_value();
      unique case ($urandom_range(4))
         0: return 16'sh8000;
         1: return -16'sd1;
         2: return 16'sd0;
         3: return 16'sd1;
         default: return 16'sh7FFF;
      endcase
   endfunction

   function automatic accroll_pkg::accroll_req_type make_req(int x, int y, int z, bit fail);
      accroll_pkg::accroll_req_type r;
      r.accel_x = 16'(x);
      r.accel_y = 16'(y);
      r.accel_z = 16'(z);
      r.read_failed = fail;
      return r;
   endfunction

   // Draws one sample. Tilted groups keep X and Z small so that the angle
   // lands near +/-90 degrees, which is what drives the offset into
   // saturation. A few samples in every style are failed reads.
   function automatic accroll_pkg::accroll_req_type make_sample(group_style_type style);
      accroll_pkg::accroll_req_type r;
      r.accel_x = 16'($urandom);
      r.accel_y = 16'($urandom);
      r.accel_z = 16'($urandom);
      unique case (style)
         STYLE_TILTED: begin
            r.accel_x = 16'(int'($urandom_range(400)) - 200);
            r.accel_z = 16'(int'($urandom_range(400)) - 200);
         end
         STYLE_CORNER: begin
            r.accel_x = corner_value();
            r.accel_y = corner_value();
            r.accel_z = corner_value();
         end
         default: ;
      endcase
      r.read_failed = ($urandom_range(99) < 5);
      return r;
   endfunction

   // Offers one request and returns in the time step of its acceptance.
   // Valid is only lowered for an idle gap, so back-to-back requests keep it
   // high across the edge.
   task automatic send_request(input accroll_pkg::accroll_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      ledger.note_sample(r);
      samples_sent++;
   endtask

   // Drops valid, lets every predicted result drain, then waits out the
   // latency of a group that may still be in flight without a result owed.
   task automatic drain();
      req_valid <= 1'b0;
      while (ledger.expected_angles.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The offset register takes the write at the next edge; the block is idle.
   task automatic write_offset(input logic signed [15:0] value);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      ledger.roll_offset = longint'(value);
      offsets_written++;
   endtask

   task automatic run_phase(int n_items, int idle_pct, int stall_pct, int hold);
      int sent;
      int k;
      int pick;
      group_style_type style;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      if (hold > 0) hold_left = hold;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(9);
         style = (pick < 2) ? STYLE_CORNER : (pick < 5) ? STYLE_TILTED : STYLE_SPREAD;
         for (k = 0; k < GROUP_SIZE && sent < n_items; k++) begin
            send_request(make_sample(style));
            sent++;
         end
      end
      drain();
   endtask

   // -------------------------------------------------------------------------
   // Result side: accepts at edges where valid and ready were both high, and
   // sets ready for the next cycle from the stall rate or the long hold-off.
   // -------------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) ledger.check_result(rsp_data);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("status: fail");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Main sequence: directed groups with the reset offset, then random phases
   // that each start with a new offset while the block is idle.
   // -------------------------------------------------------------------------
   initial begin
      ledger = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Full-scale positive and negative groups, the largest sums possible.
      repeat (4) send_request(make_req(32767, 32767, 32767, 1'b0));
      repeat (4) send_request(make_req(-32768, -32768, -32768, 1'b0));
      // All-zero sums give angle 0.
      repeat (4) send_request(make_req(0, 0, 0, 1'b0));
      // No X or Z component: straight down, -90 degrees.
      repeat (4) send_request(make_req(0, -32768, 0, 1'b0));
      // A read failure in the middle of a group clears the partial sums.
      send_request(make_req(100, 200, -300, 1'b0));
      send_request(make_req(-5, 7, 9, 1'b0));
      send_request(make_req(32767, -32768, -1, 1'b1));
      // Straight up, +90 degrees, counted from a fresh group.
      repeat (4) send_request(make_req(0, 32767, 0, 1'b0));
      drain();

      // No idling at all, offset at its upper calibration bound.
      write_offset(16'sd23040);
      run_phase(150, 0, 0, 0);
      // Sender idling; most negative offset forces saturation at the top.
      write_offset(16'sh8000);
      run_phase(150, 45, 0, 0);
      // Receiver stalling; most positive offset saturates at the bottom.
      write_offset(16'sh7FFF);
      run_phase(150, 0, 45, 0);
      // Light idling on both sides, offset at its lower calibration bound.
      write_offset(-16'sd23040);
      run_phase(150, 6, 6, 0);
      // Receiver holds off for a long stretch while the sender keeps
      // offering, so the result register fills and requests back up.
      write_offset(16'(int'($urandom_range(46080)) - 23040));
      run_phase(100, 0, 0, HOLD_CYCLES);
      // Fully random offset with light idling.
      write_offset(16'($urandom));
      run_phase(100, 6, 6, 0);

      $display("Run covered %0d sample requests and %0d checked results under %0d offsets.",
               samples_sent, ledger.results_checked, offsets_written);
      $display("Of those, %0d were failed reads and %0d angles hit the saturation bound.",
               ledger.failed_results, ledger.saturated_results);
      if (ledger.mismatches == 0 && ledger.expected_angles.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
